>>> rtl/mdp_pkg.sv
package mdp_pkg;

  localparam int unsigned HEADER_BYTES = 48;
  localparam int unsigned MAX_RANK_DEF = 8;
  localparam int unsigned MAX_NAME_DEF = 4096;

  // result queue between the parser and the output port
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPK        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 3'd6;

  localparam logic [31:0] RST_LAYERS      = 32'd30;
  localparam logic [31:0] RST_EXPERTS     = 32'd128;
  localparam logic [31:0] RST_TOPK        = 32'd8;
  localparam logic [31:0] RST_HIDDEN      = 32'd2816;
  localparam logic [15:0] RST_MAX_ENTRIES = 16'd15616;

  // field numbers within the header and within a directory entry
  localparam logic [3:0] FLD_MAGIC       = 4'd0;
  localparam logic [3:0] FLD_VERSION     = 4'd1;
  localparam logic [3:0] FLD_LAYERS      = 4'd2;
  localparam logic [3:0] FLD_EXPERTS     = 4'd3;
  localparam logic [3:0] FLD_TOPK        = 4'd4;
  localparam logic [3:0] FLD_HIDDEN      = 4'd5;
  localparam logic [3:0] FLD_FIRST_WIDE  = 4'd8;
  localparam logic [3:0] FLD_DIR_OFFSET  = 4'd8;
  localparam logic [3:0] FLD_ENTRY_COUNT = 4'd9;
  localparam logic [3:0] FLD_HDR_COUNT   = 4'd10;
  localparam logic [3:0] FLD_ENT_WIDE    = 4'd4;
  localparam logic [3:0] FLD_RANK        = 4'd7;

  localparam logic [4:0] KIND_ROLE      = 5'd10;
  localparam logic [4:0] KIND_DIM       = 5'd18;
  localparam logic [4:0] KIND_NAME_LEN  = 5'd19;
  localparam logic [4:0] KIND_NAME_BYTE = 5'd20;
  localparam logic [4:0] KIND_STATUS    = 5'd21;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_SHAPE   = 3'd2,
    ERR_ENTRIES = 3'd3,
    ERR_RANK    = 3'd4,
    ERR_NAME    = 3'd5,
    ERR_TRUNC   = 3'd6,
    ERR_OFFSET  = 3'd7
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_ENTRY  = 3'd2,
    PH_DIM    = 3'd3,
    PH_NLEN   = 3'd4,
    PH_NAME   = 3'd5,
    PH_IDLE   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [63:0] field_value;
    logic [15:0] entry_index;
    logic [11:0] sub_index;
    logic [2:0]  error_code;
    logic        finished;
    logic        last_of_run;
  } out_t;

endpackage

>>> rtl/model_directory_parser_core.sv
// Streaming parser for a model file: one byte per transaction in, decoded header
// fields, directory-entry fields, name bytes and one closing status out. A byte is
// taken every cycle unless the input is stalled; it yields zero, one or two results
// (a field, then a status), and results leave one per cycle, while the output is not
// stalled, through a 4-entry result queue. The input is stalled while the queue has
// fewer than two free slots; with the output never stalled the input rate is one
// byte per cycle. A byte's work (field shift, header checks, directory-offset
// compare) is done in the cycle it is accepted, and its results are registered in
// the queue.
module model_directory_parser_core #(
  parameter int unsigned MAX_RANK = mdp_pkg::MAX_RANK_DEF,
  parameter int unsigned MAX_NAME = mdp_pkg::MAX_NAME_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mdp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mdp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mdp_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mdp_pkg::out_t                       out_data_o
);
  import mdp_pkg::*;

  localparam int unsigned RANK_W = $clog2(MAX_RANK + 1);
  localparam int unsigned NLEFT_W = $clog2(MAX_NAME + 1);

  // configuration
  logic [31:0] magic_q, version_q, layers_q, experts_q, topk_q, hidden_q;
  logic [15:0] max_entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q       <= '0;
      version_q     <= '0;
      layers_q      <= RST_LAYERS;
      experts_q     <= RST_EXPERTS;
      topk_q        <= RST_TOPK;
      hidden_q      <= RST_HIDDEN;
      max_entries_q <= RST_MAX_ENTRIES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:       magic_q       <= cfg_data_i;
        CFG_VERSION:     version_q     <= cfg_data_i;
        CFG_LAYERS:      layers_q      <= cfg_data_i;
        CFG_EXPERTS:     experts_q     <= cfg_data_i;
        CFG_TOPK:        topk_q        <= cfg_data_i;
        CFG_HIDDEN:      hidden_q      <= cfg_data_i;
        CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // parser state
  phase_e              phase_q, phase_d;
  logic [63:0]         pos_q, pos_d;
  logic [63:0]         acc_q, acc_d;
  logic [2:0]          bif_q, bif_d;
  logic [3:0]          fn_q, fn_d;
  logic [63:0]         dir_off_q, dir_off_d;
  logic [63:0]         ent_left_q, ent_left_d;
  logic [15:0]         ent_cnt_q, ent_cnt_d;
  logic [RANK_W-1:0]   rank_q, rank_d;
  logic [RANK_W-1:0]   dim_q, dim_d;
  logic [NLEFT_W-1:0]  name_left_q, name_left_d;
  logic [11:0]         name_pos_q, name_pos_d;
  logic [1:0]          flags_q, flags_d;

  logic       in_acc;
  logic       f_v, s_v;
  out_t       f_res, s_res, res_a, res_b;
  logic [1:0] n_res;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    logic [63:0] acc_new;
    logic [63:0] val;
    logic [2:0]  bif_nx;
    logic        w4;
    logic        use_collect;
    logic        done;
    logic        fin;
    logic        entry_done;
    logic [RANK_W-1:0] dim_nx;
    err_e        err;

    phase_d     = phase_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    bif_d       = bif_q;
    fn_d        = fn_q;
    dir_off_d   = dir_off_q;
    ent_left_d  = ent_left_q;
    ent_cnt_d   = ent_cnt_q;
    rank_d      = rank_q;
    dim_d       = dim_q;
    name_left_d = name_left_q;
    name_pos_d  = name_pos_q;
    flags_d     = flags_q;
    f_v         = 1'b0;
    s_v         = 1'b0;
    f_res       = '0;
    s_res       = '0;
    acc_new     = '0;
    val         = '0;
    bif_nx      = '0;
    w4          = 1'b0;
    use_collect = 1'b0;
    done        = 1'b0;
    fin         = 1'b0;
    entry_done  = 1'b0;
    dim_nx      = '0;
    err         = ERR_NONE;

    if (in_acc) begin
      if (in_data_i.first_byte) begin
        phase_d     = PH_HEADER;
        pos_d       = '0;
        acc_d       = '0;
        bif_d       = '0;
        fn_d        = '0;
        dir_off_d   = '0;
        ent_left_d  = '0;
        ent_cnt_d   = '0;
        rank_d      = '0;
        dim_d       = '0;
        name_left_d = '0;
        name_pos_d  = '0;
        flags_d     = '0;
      end

      if (phase_d != PH_IDLE) begin
        // position of this byte is compared before it advances
        if (phase_d == PH_SKIP && pos_d >= dir_off_d) begin
          phase_d = PH_ENTRY;
        end
        pos_d = pos_d + 64'd1;

        // little-endian byte assembly, 4- or 8-byte fields
        case (phase_d)
          PH_HEADER: begin
            use_collect = 1'b1;
            w4 = fn_d < FLD_FIRST_WIDE;
          end
          PH_ENTRY: begin
            use_collect = 1'b1;
            w4 = (fn_d < FLD_ENT_WIDE) || (fn_d >= FLD_RANK);
          end
          PH_DIM: use_collect = 1'b1;
          PH_NLEN: begin
            use_collect = 1'b1;
            w4 = 1'b1;
          end
          default: ;
        endcase
        acc_new = acc_d | ({56'd0, in_data_i.data_byte} << {bif_d, 3'b000});
        bif_nx  = bif_d + 3'd1;
        done    = use_collect && ((bif_nx == 3'd0) || (w4 && bif_nx[2]));
        val     = acc_new;
        if (use_collect) begin
          if (done) begin
            acc_d = '0;
            bif_d = '0;
          end else begin
            acc_d = acc_new;
            bif_d = bif_nx;
          end
        end

        case (phase_d)
          PH_HEADER: begin
            if (done) begin
              f_v = 1'b1;
              f_res.field_kind  = 5'(fn_d);
              f_res.field_value = val;
              case (fn_d)
                FLD_MAGIC:   if (val != {32'd0, magic_q})   flags_d[0] = 1'b1;
                FLD_VERSION: if (val != {32'd0, version_q}) flags_d[0] = 1'b1;
                FLD_LAYERS:  if (val != {32'd0, layers_q})  flags_d[1] = 1'b1;
                FLD_EXPERTS: if (val != {32'd0, experts_q}) flags_d[1] = 1'b1;
                FLD_TOPK:    if (val != {32'd0, topk_q})    flags_d[1] = 1'b1;
                FLD_HIDDEN:  if (val != {32'd0, hidden_q})  flags_d[1] = 1'b1;
                FLD_DIR_OFFSET:  dir_off_d  = val;
                FLD_ENTRY_COUNT: ent_left_d = val;
                default: ;
              endcase
              fn_d = fn_d + 4'd1;
              if (fn_d >= FLD_HDR_COUNT) begin
                fn_d = '0;
                if (flags_d[0]) err = ERR_MAGIC;
                else if (flags_d[1]) err = ERR_SHAPE;
                else if (ent_left_d > {48'd0, max_entries_q}) err = ERR_ENTRIES;
                else if (dir_off_d < 64'(HEADER_BYTES)) err = ERR_OFFSET;
                else if (ent_left_d == 64'd0) fin = 1'b1;
                else if (dir_off_d == 64'(HEADER_BYTES)) phase_d = PH_ENTRY;
                else phase_d = PH_SKIP;
              end
            end
          end
          PH_ENTRY: begin
            if (done) begin
              f_v = 1'b1;
              f_res.field_kind  = KIND_ROLE + 5'(fn_d);
              f_res.field_value = val;
              f_res.entry_index = ent_cnt_d;
              if (fn_d >= FLD_RANK) begin
                fn_d = '0;
                if (val > 64'(MAX_RANK)) begin
                  err = ERR_RANK;
                end else begin
                  rank_d  = val[RANK_W-1:0];
                  dim_d   = '0;
                  phase_d = (val[RANK_W-1:0] != '0) ? PH_DIM : PH_NLEN;
                end
              end else begin
                fn_d = fn_d + 4'd1;
              end
            end
          end
          PH_DIM: begin
            if (done) begin
              f_v = 1'b1;
              f_res.field_kind  = KIND_DIM;
              f_res.field_value = val;
              f_res.entry_index = ent_cnt_d;
              f_res.sub_index   = 12'(dim_d);
              dim_nx = dim_d + RANK_W'(1);
              dim_d  = dim_nx;
              if (dim_nx >= rank_d) phase_d = PH_NLEN;
            end
          end
          PH_NLEN: begin
            if (done) begin
              f_v = 1'b1;
              f_res.field_kind  = KIND_NAME_LEN;
              f_res.field_value = val;
              f_res.entry_index = ent_cnt_d;
              if (val > 64'(MAX_NAME)) begin
                err = ERR_NAME;
              end else if (val == 64'd0) begin
                entry_done = 1'b1;
              end else begin
                name_left_d = val[NLEFT_W-1:0];
                name_pos_d  = '0;
                phase_d     = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            f_v = 1'b1;
            f_res.field_kind  = KIND_NAME_BYTE;
            f_res.field_value = {56'd0, in_data_i.data_byte};
            f_res.entry_index = ent_cnt_d;
            f_res.sub_index   = name_pos_d;
            name_pos_d = name_pos_d + 12'd1;
            if (name_left_d != '0) name_left_d = name_left_d - NLEFT_W'(1);
            if (name_left_d == '0) entry_done = 1'b1;
          end
          default: ;
        endcase

        if (entry_done) begin
          ent_cnt_d  = ent_cnt_d + 16'd1;
          ent_left_d = ent_left_d - 64'd1;
          fn_d       = '0;
          phase_d    = PH_ENTRY;
          if (ent_left_d == 64'd0) fin = 1'b1;
        end

        if (err != ERR_NONE || fin || in_data_i.last_byte) begin
          s_v = 1'b1;
          s_res.field_kind  = KIND_STATUS;
          s_res.entry_index = ent_cnt_d;
          s_res.last_of_run = 1'b1;
          if (err != ERR_NONE) s_res.error_code = err;
          else if (fin) s_res.finished = 1'b1;
          else s_res.error_code = ERR_TRUNC;
          phase_d = PH_IDLE;
        end
        f_res.last_of_run = !s_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      acc_q       <= '0;
      bif_q       <= '0;
      fn_q        <= '0;
      dir_off_q   <= '0;
      ent_left_q  <= '0;
      ent_cnt_q   <= '0;
      rank_q      <= '0;
      dim_q       <= '0;
      name_left_q <= '0;
      name_pos_q  <= '0;
      flags_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      bif_q       <= bif_d;
      fn_q        <= fn_d;
      dir_off_q   <= dir_off_d;
      ent_left_q  <= ent_left_d;
      ent_cnt_q   <= ent_cnt_d;
      rank_q      <= rank_d;
      dim_q       <= dim_d;
      name_left_q <= name_left_d;
      name_pos_q  <= name_pos_d;
      flags_q     <= flags_d;
    end
  end

  // result queue: up to two writes, one read per cycle
  assign res_a = f_v ? f_res : s_res;
  assign res_b = s_res;
  assign n_res = {1'b0, f_v} + {1'b0, s_v};

  out_t                fifo_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wptr_q, rptr_q, wptr_b;
  logic [RQ_CNT_W-1:0] count_q;
  logic                pop;

  assign wptr_b      = wptr_q + RQ_PTR_W'(1);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = fifo_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = count_q > RQ_CNT_W'(RQ_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RQ_DEPTH; i++) begin
      if (in_acc && n_res != 2'd0 && wptr_q == RQ_PTR_W'(i)) begin
        fifo_q[i] <= res_a;
      end else if (in_acc && n_res == 2'd2 && wptr_b == RQ_PTR_W'(i)) begin
        fifo_q[i] <= res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (in_acc) wptr_q <= wptr_q + RQ_PTR_W'(n_res);
      if (pop) rptr_q <= rptr_q + RQ_PTR_W'(1);
      count_q <= count_q + (in_acc ? RQ_CNT_W'(n_res) : '0) - RQ_CNT_W'(pop);
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_pair_is_field_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && n_res == 2'd2) |->
      (res_b.field_kind == KIND_STATUS && !res_a.last_of_run && res_b.last_of_run))
    else $error("two results must be a field followed by the closing status");

  a_status_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_v) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after a status result");

endmodule
